// ===== hdl/cmhd_pkg.sv =====
`default_nettype none
package cmhd_pkg;

  localparam int WORD_W = 64;
  localparam int CHAR_W = 8;
  localparam int CHARS  = WORD_W / CHAR_W;
  localparam int LEN_W  = 4;
  localparam int DIST_W = 4;

  localparam logic [LEN_W-1:0]  LEN_RESET = 4'd8;
  localparam logic [DIST_W-1:0] MIN_RESET = 4'd8;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] min_dist;
    logic              pair;
  } tok_t;

  function automatic logic [DIST_W-1:0] char_mismatches(
    input logic [WORD_W-1:0] a,
    input logic [WORD_W-1:0] b,
    input logic [LEN_W-1:0]  len
  );
    logic [DIST_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHARS; i++) begin
      if ((LEN_W'(i) < len) && (a[i*CHAR_W +: CHAR_W] != b[i*CHAR_W +: CHAR_W])) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cmhd_cell.sv =====
`default_nettype none
module cmhd_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire cmhd_pkg::tok_t   tok_i,
  output cmhd_pkg::tok_t        tok_o
);
  import cmhd_pkg::*;

  logic [WORD_W-1:0] word_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              occupied;
  logic [DIST_W-1:0] diff_cnt;

  assign occupied = CNT_W'(IDX) < count_i;
  assign diff_cnt = char_mismatches(tok_i.word, word_r, tok_i.len);

  always_comb begin
    tok_nxt = tok_i;
    if (occupied) begin
      tok_nxt.pair = 1'b1;
      if (diff_cnt < tok_i.min_dist) begin
        tok_nxt.min_dist = diff_cnt;
      end
    end
  end

  // store the passing word in the first free cell
  always_ff @(posedge clk) begin
    if (tok_i.valid && (count_i == CNT_W'(IDX))) begin
      word_r <= tok_i.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.last     <= tok_nxt.last;
    tok_r.word     <= tok_nxt.word;
    tok_r.len      <= tok_nxt.len;
    tok_r.min_dist <= tok_nxt.min_dist;
    tok_r.pair     <= tok_nxt.pair;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ===== hdl/code_minimum_hamming_distance.sv =====
// Items are taken one at a time: in_tready stays low from accept until the word
// leaves the last cell, and after a last item until its result is registered;
// each word walks the full row of MAX_WORDS store cells, one cell per cycle.
// A result held in the output register stalls the next last item until out_tready.
// Reset (rst_n, synchronous, active low): empty store, minimum 8, flags clear,
// word_length 8.
`default_nettype none
module code_minimum_hamming_distance #(
  parameter int MAX_WORDS = 16,
  parameter int MAX_CHARS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,   // word_length
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // word_chars
  input  wire logic        in_tlast,   // last_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // min_distance[3:0], pair_found[4], store_overflow[5]
);
  import cmhd_pkg::*;

  localparam int CNT_W = $clog2(MAX_WORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  word_length_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DIST_W-1:0] min_r, min_nxt;
  logic              pair_r, pair_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic [LEN_W-1:0]  len_eff;
  logic              in_acc;
  logic              out_free;
  tok_t              launch;
  tok_t              tok_s [MAX_WORDS+1];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign len_eff = (word_length_r > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : word_length_r;

  always_comb begin
    launch.valid    = in_acc;
    launch.last     = in_tlast;
    launch.word     = in_tdata;
    launch.len      = len_eff;
    launch.min_dist = min_r;
    launch.pair     = pair_r;
  end

  assign tok_s[0] = launch;

  for (genvar k = 0; k < MAX_WORDS; k++) begin : g_cell
    cmhd_cell #(
      .CNT_W (CNT_W),
      .IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count_i (count_r),
      .tok_i   (tok_s[k]),
      .tok_o   (tok_s[k+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    pair_nxt      = pair_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (tok_s[MAX_WORDS].valid) begin
          min_nxt  = tok_s[MAX_WORDS].min_dist;
          pair_nxt = tok_s[MAX_WORDS].pair;
          if (count_r < CNT_W'(MAX_WORDS)) begin
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = tok_s[MAX_WORDS].last ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, ovf_r, pair_r, (pair_r ? min_r : DIST_W'(0))};
          count_nxt     = '0;
          min_nxt       = MIN_RESET;
          pair_nxt      = 1'b0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      word_length_r <= LEN_RESET;
      count_r       <= '0;
      min_r         <= MIN_RESET;
      pair_r        <= 1'b0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      pair_r      <= pair_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        word_length_r <= cfg_data;
      end
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/cmhd_checker.sv =====
`default_nettype none
module cmhd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one item in flight at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one in flight");

  // no pair means distance zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> out_tdata[3:0] == 4'd0)
    else $error("distance set without a pair");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd8 && out_tdata[7:6] == 2'b00)
    else $error("result out of range");

endmodule

bind code_minimum_hamming_distance cmhd_checker u_cmhd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
